[rtl/bbmm_pkg.sv]
// shared types, register codes and constants of the balance robot motor mixer
`timescale 1ns / 1ps
`default_nettype none

package bbmm_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 21;

	localparam int INTEGRAL_BOUND_DEF = 10000;
	localparam int INTEGRAL_W = 15;

	localparam logic signed [7:0] DIR_STEP = 8'sd60;
	localparam logic signed [5:0] STEER_TARGET = 6'sd15;

	localparam logic signed [16:0] RST_BALANCE_ANGLE = -17'sd2048;
	localparam logic signed [20:0] RST_UPRIGHT_KP = -21'sd84480;
	localparam logic signed [20:0] RST_UPRIGHT_KD = -21'sd563;
	localparam logic signed [20:0] RST_SPEED_KP = 21'sd30720;
	localparam logic signed [20:0] RST_SPEED_KI = 21'sd154;
	localparam logic signed [20:0] RST_STEER_KP = 21'sd10240;
	localparam logic signed [20:0] RST_STEER_KD = -21'sd205;
	localparam logic [14:0] RST_DRIVE_LIMIT = 15'd7200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BALANCE_ANGLE = 8'd0,
		REG_UPRIGHT_KP = 8'd1,
		REG_UPRIGHT_KD = 8'd2,
		REG_SPEED_KP = 8'd3,
		REG_SPEED_KI = 8'd4,
		REG_STEER_KP = 8'd5,
		REG_STEER_KD = 8'd6,
		REG_DRIVE_LIMIT = 8'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [16:0] balance_angle;
		logic signed [20:0] upright_kp;
		logic signed [20:0] upright_kd;
		logic signed [20:0] speed_kp;
		logic signed [20:0] speed_ki;
		logic signed [20:0] steer_kp;
		logic signed [20:0] steer_kd;
		logic [14:0] drive_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] pitch;
		logic signed [15:0] pitch_rate;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] wheel_delta;
		logic signed [1:0] drive_dir;
		logic signed [1:0] steer_dir;
	} item_t;

	// raw products, scaled down in the mixing stage
	typedef struct packed {
		logic signed [38:0] up_p;
		logic signed [36:0] upd_p;
		logic signed [37:0] spd_p;
		logic signed [35:0] ki_p;
		logic signed [26:0] stk_p;
		logic signed [36:0] std_p;
	} prod_t;

endpackage

`default_nettype wire

[rtl/bbmm_ifs.sv]
// valid/ready channel interfaces: sensor words in, drive words out, register writes
`timescale 1ns / 1ps
`default_nettype none

interface bbmm_sensor_if;
	logic valid;
	logic ready;
	logic signed [16:0] pitch;
	logic signed [15:0] pitch_rate;
	logic signed [15:0] yaw_rate;
	logic signed [15:0] wheel_delta;
	logic signed [1:0] drive_dir;
	logic signed [1:0] steer_dir;

	modport source (output valid, pitch, pitch_rate, yaw_rate, wheel_delta, drive_dir,
		steer_dir, input ready);
	modport sink (input valid, pitch, pitch_rate, yaw_rate, wheel_delta, drive_dir,
		steer_dir, output ready);
endinterface

interface bbmm_drive_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;

	modport source (output valid, left_drive, right_drive, input ready);
	modport sink (input valid, left_drive, right_drive, output ready);
endinterface

interface bbmm_cfg_if;
	logic valid;
	logic ready;
	logic [bbmm_pkg::CFG_IDX_W-1:0] index;
	logic [bbmm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/bbmm_regs.sv]
// configuration register file with write decoder
`timescale 1ns / 1ps
`default_nettype none

module bbmm_regs (
	input wire logic clk,
	input wire logic arst_n,
	bbmm_cfg_if.sink cfg,
	output bbmm_pkg::cfg_t regs
);

	bbmm_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.balance_angle <= bbmm_pkg::RST_BALANCE_ANGLE;
			regs_q.upright_kp <= bbmm_pkg::RST_UPRIGHT_KP;
			regs_q.upright_kd <= bbmm_pkg::RST_UPRIGHT_KD;
			regs_q.speed_kp <= bbmm_pkg::RST_SPEED_KP;
			regs_q.speed_ki <= bbmm_pkg::RST_SPEED_KI;
			regs_q.steer_kp <= bbmm_pkg::RST_STEER_KP;
			regs_q.steer_kd <= bbmm_pkg::RST_STEER_KD;
			regs_q.drive_limit <= bbmm_pkg::RST_DRIVE_LIMIT;
		end else if (cfg.valid) begin
			unique case (bbmm_pkg::reg_idx_t'(cfg.index))
				bbmm_pkg::REG_BALANCE_ANGLE: regs_q.balance_angle <= cfg.data[16:0];
				bbmm_pkg::REG_UPRIGHT_KP: regs_q.upright_kp <= cfg.data;
				bbmm_pkg::REG_UPRIGHT_KD: regs_q.upright_kd <= cfg.data;
				bbmm_pkg::REG_SPEED_KP: regs_q.speed_kp <= cfg.data;
				bbmm_pkg::REG_SPEED_KI: regs_q.speed_ki <= cfg.data;
				bbmm_pkg::REG_STEER_KP: regs_q.steer_kp <= cfg.data;
				bbmm_pkg::REG_STEER_KD: regs_q.steer_kd <= cfg.data;
				bbmm_pkg::REG_DRIVE_LIMIT: regs_q.drive_limit <= cfg.data[14:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/bbmm_terms.sv]
// encoder integral update and the six gain products
`timescale 1ns / 1ps
`default_nettype none

module bbmm_terms #(
	parameter int INTEGRAL_BOUND = bbmm_pkg::INTEGRAL_BOUND_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bbmm_pkg::cfg_t regs,
	input wire bbmm_pkg::item_t item_s1,
	input wire logic adv,
	output bbmm_pkg::prod_t prod_s2,
	output logic signed [bbmm_pkg::INTEGRAL_W-1:0] integral
);

	localparam logic signed [17:0] BOUND = 18'(INTEGRAL_BOUND);

	logic signed [bbmm_pkg::INTEGRAL_W-1:0] wheel_integral_q;
	logic signed [bbmm_pkg::INTEGRAL_W-1:0] integral_nxt;
	logic signed [7:0] dir_term;
	logic signed [17:0] integral_sum;
	logic signed [5:0] steer_target;
	logic signed [16:0] neg_delta;
	logic signed [17:0] pitch_err;
	bbmm_pkg::prod_t prod;

	assign integral = wheel_integral_q;

	always_comb begin
		dir_term = $signed({{6{item_s1.drive_dir[1]}}, item_s1.drive_dir}) * bbmm_pkg::DIR_STEP;
		integral_sum = 18'(wheel_integral_q) - 18'(item_s1.wheel_delta) + 18'(dir_term);
		if (integral_sum > BOUND) begin
			integral_nxt = bbmm_pkg::INTEGRAL_W'(BOUND);
		end else if (integral_sum < -BOUND) begin
			integral_nxt = bbmm_pkg::INTEGRAL_W'(-BOUND);
		end else begin
			integral_nxt = bbmm_pkg::INTEGRAL_W'(integral_sum);
		end

		steer_target = $signed({{4{item_s1.steer_dir[1]}}, item_s1.steer_dir})
			* bbmm_pkg::STEER_TARGET;
		neg_delta = -17'(item_s1.wheel_delta);
		pitch_err = 18'(item_s1.pitch) - 18'(regs.balance_angle);

		prod.up_p = 39'(regs.upright_kp) * 39'(pitch_err);
		prod.upd_p = 37'(regs.upright_kd) * 37'(item_s1.pitch_rate);
		prod.spd_p = 38'(regs.speed_kp) * 38'(neg_delta);
		// integral term uses the value updated by this same word
		prod.ki_p = 36'(regs.speed_ki) * 36'(integral_nxt);
		prod.stk_p = 27'(regs.steer_kp) * 27'(steer_target);
		prod.std_p = 37'(regs.steer_kd) * 37'(item_s1.yaw_rate);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_integral_q <= '0;
		end else if (adv) begin
			wheel_integral_q <= integral_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod;
		end
	end

endmodule

`default_nettype wire

[rtl/bbmm_mix.sv]
// scaling toward zero, motor mixing and drive saturation into the output register
`timescale 1ns / 1ps
`default_nettype none

module bbmm_mix (
	input wire logic clk,
	input wire bbmm_pkg::prod_t prod_s2,
	input wire logic [14:0] drive_limit,
	input wire logic load,
	output logic signed [15:0] left_q,
	output logic signed [15:0] right_q
);

	function automatic logic signed [33:0] div256(input logic signed [38:0] p);
		logic signed [38:0] biased;
		biased = p + (p[38] ? 39'sd255 : 39'sd0);
		return 34'(biased >>> 8);
	endfunction

	function automatic logic signed [33:0] div65536(input logic signed [38:0] p);
		logic signed [38:0] biased;
		biased = p + (p[38] ? 39'sd65535 : 39'sd0);
		return 34'(biased >>> 16);
	endfunction

	function automatic logic signed [15:0] sat(input logic signed [33:0] v,
		input logic signed [33:0] lim);
		logic signed [33:0] r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return 16'(r);
	endfunction

	logic signed [33:0] base;
	logic signed [33:0] turn;
	logic signed [33:0] lim;

	always_comb begin
		base = div65536(prod_s2.up_p) + div256(39'(prod_s2.upd_p))
			+ div256(39'(prod_s2.spd_p)) + div256(39'(prod_s2.ki_p));
		turn = div256(39'(prod_s2.stk_p)) + div256(39'(prod_s2.std_p));
		// limit never exceeds 32767, so the int16 saturation is covered by it
		lim = $signed({19'd0, drive_limit});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q <= sat(base - turn, lim);
			right_q <= sat(base + turn, lim);
		end
	end

endmodule

`default_nettype wire

[rtl/balance_robot_motor_mixer.sv]
// top level: sensor word register, product stage, mixing output stage
`timescale 1ns / 1ps
`default_nettype none

// Two-wheel balance controller with left/right motor mixing.
// sensor: one word per control tick (pitch, gyro rates, encoder delta, drive
//   and steer directions); taken when valid and ready are high at a clock edge.
// drive: one word per sensor word with left_drive and right_drive, each held
//   within plus or minus drive_limit.
// cfg: register writes by index, always ready; write only while no word is in
//   flight.
// The drive word passes through the input register, the product register and the
//   output register after its sensor word is taken.
// Throughput: one word per cycle unless drive stalls; the encoder integral
//   add-and-clamp recurrence feeding the integral gain multiplier sets it.
// A stalled drive word holds; the stages in front keep filling bubbles, so the
//   sensor side stays ready until all three stages are full.
// Reset clears the encoder integral and all stage valids and loads the default
//   gains; no clearing pass is needed.

module balance_robot_motor_mixer #(
	parameter int INTEGRAL_BOUND = bbmm_pkg::INTEGRAL_BOUND_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bbmm_sensor_if.sink sensor,
	bbmm_drive_if.source drive,
	bbmm_cfg_if.sink cfg
);

	bbmm_pkg::cfg_t regs;
	bbmm_pkg::item_t item_s1;
	bbmm_pkg::prod_t prod_s2;
	logic signed [bbmm_pkg::INTEGRAL_W-1:0] integral;

	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic ready_out;
	logic ready_s2;
	logic ready_s1;
	logic adv_s1;
	logic adv_s2;

	assign ready_out = !out_valid_q || drive.ready;
	assign ready_s2 = !valid_s2 || ready_out;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv_s1 = valid_s1 && ready_s2;
	assign adv_s2 = valid_s2 && ready_out;

	assign sensor.ready = ready_s1;
	assign drive.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sensor.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && ready_s1) begin
			item_s1.pitch <= sensor.pitch;
			item_s1.pitch_rate <= sensor.pitch_rate;
			item_s1.yaw_rate <= sensor.yaw_rate;
			item_s1.wheel_delta <= sensor.wheel_delta;
			item_s1.drive_dir <= sensor.drive_dir;
			item_s1.steer_dir <= sensor.steer_dir;
		end
	end

	bbmm_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	bbmm_terms #(
		.INTEGRAL_BOUND(INTEGRAL_BOUND)
	) u_terms (
		.clk(clk),
		.arst_n(arst_n),
		.regs(regs),
		.item_s1(item_s1),
		.adv(adv_s1),
		.prod_s2(prod_s2),
		.integral(integral)
	);

	bbmm_mix u_mix (
		.clk(clk),
		.prod_s2(prod_s2),
		.drive_limit(regs.drive_limit),
		.load(adv_s2),
		.left_q(drive.left_drive),
		.right_q(drive.right_drive)
	);

`ifndef SYNTHESIS
	a_integral_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(integral <= $signed(18'(INTEGRAL_BOUND))) && (integral >= -$signed(18'(INTEGRAL_BOUND))))
		else $error("encoder integral outside its bound");

	a_integral_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(integral))
		else $error("encoder integral changed without a word advancing");

	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> (drive.left_drive <= $signed({1'b0, regs.drive_limit}))
			&& (drive.left_drive >= -$signed({1'b0, regs.drive_limit}))
			&& (drive.right_drive <= $signed({1'b0, regs.drive_limit}))
			&& (drive.right_drive >= -$signed({1'b0, regs.drive_limit})))
		else $error("drive word exceeds drive limit");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_valid_q && !drive.ready) |-> !sensor.ready)
		else $error("sensor word accepted into a full pipeline");
`endif

endmodule

`default_nettype wire
